### rtl/hsl2rgb_pkg.sv
// Shared types and constants of the HSL to RGB converter.
package hsl2rgb_pkg;

  localparam int NSTAGE = 6;

  // One turn of hue in sixteenths of a degree, and its multiples.
  localparam logic [12:0] HUE_TURN = 13'd5760;
  localparam logic [16:0] HUE_BIAS = 17'd34560;  // six turns, makes any hue positive
  localparam logic [16:0] HUE_8T   = 17'd46080;
  localparam logic [16:0] HUE_4T   = 17'd23040;
  localparam logic [14:0] HUE_2T   = 15'd11520;
  localparam logic [13:0] TURN_W   = 14'd5760;

  // Channel hue offsets: 0, 8 and 4 twelfths of a turn.
  localparam logic [12:0] OFS_RED   = 13'd0;
  localparam logic [12:0] OFS_GREEN = 13'd3840;
  localparam logic [12:0] OFS_BLUE  = 13'd1920;

  localparam logic signed [13:0] RAMP_LO  = 14'sd1440;
  localparam logic signed [13:0] RAMP_HI  = 14'sd4320;
  localparam logic signed [13:0] RAMP_MAX = 14'sd480;

  localparam logic [8:0] UNIT = 9'd256;
  localparam logic [7:0] HALF = 8'd128;

  // Final scale: divide by 256*480 = 122880 = 2^13 * 15, rounded to nearest.
  localparam logic [25:0] DEN       = 26'd122880;
  localparam logic [24:0] VMAX      = 25'd31457280;
  localparam logic [24:0] DEN_HALF  = 25'd61440;
  localparam int          DEN_SHIFT = 13;
  localparam logic [24:0] RECIP_15  = 25'd4370;   // ceil(2^16 / 15), exact for w < 4096

  typedef logic [12:0]        hue_t;
  typedef logic [15:0]        chroma_t;
  typedef logic [8:0]         level_t;
  typedef logic signed [9:0]  ramp_t;

  typedef struct packed {
    logic [NSTAGE-1:0] load;
  } stage_ctl_t;

endpackage

### rtl/hsl2rgb_in_if.sv
// Input channel: one HSL item per handshake.
interface hsl2rgb_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] hue;
  logic [8:0]  saturation;
  logic [8:0]  lightness;

  modport source (output valid, hue, saturation, lightness, input ready);
  modport sink   (input valid, hue, saturation, lightness, output ready);
endinterface

### rtl/hsl2rgb_out_if.sv
// Output channel: one RGB item per handshake.
interface hsl2rgb_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] red;
  logic [8:0] green;
  logic [8:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

### rtl/hsl2rgb_front.sv
// Front stages: saturate inputs, wrap hue into one turn, form chroma product.
module hsl2rgb_front (
  input  logic                    clk,
  input  hsl2rgb_pkg::stage_ctl_t ctl,
  input  logic [15:0]             hue,
  input  logic [8:0]              saturation,
  input  logic [8:0]              lightness,
  output hsl2rgb_pkg::hue_t       hue_wrap,
  output hsl2rgb_pkg::chroma_t    chroma,
  output hsl2rgb_pkg::level_t     light
);

  logic [16:0] biased;
  logic [16:0] rem8;
  logic [16:0] rem4;
  logic [8:0]  s_sat;
  logic [8:0]  l_sat;
  logic [7:0]  m_min;

  logic [14:0] hue_part;
  logic [8:0]  s_q;
  logic [8:0]  l_q;
  logic [7:0]  m_q;

  logic [14:0] rem2;
  logic [13:0] rem1;

  // Stage 0: bias, then strip eight and four turns; saturate s and l, take min(l, 1-l).
  always_comb begin
    biased = 17'({hue[15], hue}) + hsl2rgb_pkg::HUE_BIAS;
    rem8   = (biased >= hsl2rgb_pkg::HUE_8T) ? biased - hsl2rgb_pkg::HUE_8T : biased;
    rem4   = (rem8 >= hsl2rgb_pkg::HUE_4T) ? rem8 - hsl2rgb_pkg::HUE_4T : rem8;
    s_sat  = (saturation > hsl2rgb_pkg::UNIT) ? hsl2rgb_pkg::UNIT : saturation;
    l_sat  = (lightness > hsl2rgb_pkg::UNIT) ? hsl2rgb_pkg::UNIT : lightness;
    m_min  = (l_sat > 9'(hsl2rgb_pkg::HALF)) ? 8'(hsl2rgb_pkg::UNIT - l_sat) : l_sat[7:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      hue_part <= rem4[14:0];
      s_q      <= s_sat;
      l_q      <= l_sat;
      m_q      <= m_min;
    end
  end

  // Stage 1: strip two turns and one turn; multiply saturation by min(l, 1-l).
  always_comb begin
    rem2 = (hue_part >= hsl2rgb_pkg::HUE_2T) ? hue_part - hsl2rgb_pkg::HUE_2T : hue_part;
    rem1 = (rem2[13:0] >= hsl2rgb_pkg::TURN_W) ? rem2[13:0] - hsl2rgb_pkg::TURN_W
                                                : rem2[13:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      hue_wrap <= rem1[12:0];
      chroma   <= 16'(s_q) * 16'(m_q);
      light    <= l_q;
    end
  end

endmodule

### rtl/hsl2rgb_chan.sv
// One color channel: hue ramp, chroma scaling and rounding to 0..256.
module hsl2rgb_chan #(
  parameter logic [12:0] OFFSET = 13'd0
) (
  input  logic                    clk,
  input  hsl2rgb_pkg::stage_ctl_t ctl,
  input  hsl2rgb_pkg::hue_t       hue_wrap,
  input  hsl2rgb_pkg::chroma_t    chroma,
  input  hsl2rgb_pkg::level_t     light,
  output logic [8:0]              level
);

  logic [13:0]        p_sum;
  logic [12:0]        p_wrap;
  logic signed [13:0] t_rise;
  logic signed [13:0] t_fall;
  logic signed [13:0] t_min;
  logic signed [13:0] t_clip;

  hsl2rgb_pkg::ramp_t   t_q;
  hsl2rgb_pkg::chroma_t sm_q;
  logic [8:0]           l_q2;

  logic signed [26:0] prod;
  logic [8:0]         l_q3;

  logic [25:0]        l_den;
  logic signed [26:0] v_raw;
  logic [24:0]        v_clip;
  logic [24:0]        v_round;
  logic [11:0]        w_q;

  logic [24:0]        q_wide;

  // Stage 2: phase of this channel and its clipped ramp.
  always_comb begin
    p_sum  = {1'b0, hue_wrap} + {1'b0, OFFSET};
    p_wrap = (p_sum >= hsl2rgb_pkg::TURN_W) ? 13'(p_sum - hsl2rgb_pkg::TURN_W)
                                            : p_sum[12:0];
    t_rise = $signed({1'b0, p_wrap}) - hsl2rgb_pkg::RAMP_LO;
    t_fall = hsl2rgb_pkg::RAMP_HI - $signed({1'b0, p_wrap});
    t_min  = (t_rise < t_fall) ? t_rise : t_fall;
    if (t_min > hsl2rgb_pkg::RAMP_MAX) begin
      t_clip = hsl2rgb_pkg::RAMP_MAX;
    end else if (t_min < -hsl2rgb_pkg::RAMP_MAX) begin
      t_clip = -hsl2rgb_pkg::RAMP_MAX;
    end else begin
      t_clip = t_min;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      t_q  <= 10'(t_clip);
      sm_q <= chroma;
      l_q2 <= light;
    end
  end

  // Stage 3: chroma times ramp.
  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      prod <= 27'($signed({1'b0, sm_q})) * 27'(t_q);
      l_q3 <= l_q2;
    end
  end

  // Stage 4: subtract from scaled lightness, clamp, add half and drop 2^13.
  always_comb begin
    l_den = 26'(l_q3) * hsl2rgb_pkg::DEN;
    v_raw = $signed({1'b0, l_den}) - prod;
    if (v_raw[26]) begin
      v_clip = '0;
    end else if (v_raw[25:0] > 26'(hsl2rgb_pkg::VMAX)) begin
      v_clip = hsl2rgb_pkg::VMAX;
    end else begin
      v_clip = v_raw[24:0];
    end
    v_round = v_clip + hsl2rgb_pkg::DEN_HALF;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      w_q <= v_round[24:hsl2rgb_pkg::DEN_SHIFT];
    end
  end

  // Stage 5: divide by fifteen through the reciprocal.
  always_comb begin
    q_wide = 25'(w_q) * hsl2rgb_pkg::RECIP_15;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[5]) begin
      level <= q_wide[24:16];
    end
  end

endmodule

### rtl/hsl_to_rgb_converter_unit.sv
// Top level of the HSL to RGB converter: stage control and channel datapaths.
//
// Converts one HSL pixel (hue in sixteenths of a degree, any 16-bit value,
// wrapped modulo 360 degrees; saturation and lightness on 0..256, larger
// values treated as 256) into red, green and blue on 0..256, rounded to
// nearest with exact halves rounding up. The datapath is six register
// stages: hue bias and coarse turn removal; fine turn removal and the
// saturation-times-min(l, 1-l) product; per-channel hue ramp; ramp multiply;
// lightness subtract, clamp and rounding shift; divide by fifteen. An item
// enters every clock cycle unless back-pressure holds the input. Each
// stage has its own valid bit and loads whenever it is empty or the stage
// after it moves, so a stalled output holds its item while earlier stages
// keep filling bubbles; the input is ready unless all six stages are full
// and the output is stalled. Reset clears the valid bits only.
module hsl_to_rgb_converter_unit (
  input  logic          clk,
  input  logic          rst,
  hsl2rgb_in_if.sink    hsl,
  hsl2rgb_out_if.source rgb
);

  localparam int NS = hsl2rgb_pkg::NSTAGE;

  logic [NS-1:0] vld;
  logic [NS-1:0] vld_next;
  logic [NS-1:0] rdy;

  hsl2rgb_pkg::stage_ctl_t ctl;

  hsl2rgb_pkg::hue_t    hue_wrap;
  hsl2rgb_pkg::chroma_t chroma;
  hsl2rgb_pkg::level_t  light;

  // Ready ripples back from the output: a stage loads when it is empty or
  // its item moves on in the same cycle.
  always_comb begin
    rdy[NS-1] = !vld[NS-1] || rgb.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
    ctl.load = rdy;
  end

  // Advance valid bits along with the data; a stage that cannot load holds.
  always_comb begin
    vld_next[0] = rdy[0] ? hsl.valid : vld[0];
    for (int i = 1; i < NS; i++) begin
      vld_next[i] = rdy[i] ? vld[i-1] : vld[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign hsl.ready = rdy[0];
  assign rgb.valid = vld[NS-1];

  hsl2rgb_front u_front (
    .clk        (clk),
    .ctl        (ctl),
    .hue        (hsl.hue),
    .saturation (hsl.saturation),
    .lightness  (hsl.lightness),
    .hue_wrap   (hue_wrap),
    .chroma     (chroma),
    .light      (light)
  );

  hsl2rgb_chan #(.OFFSET(hsl2rgb_pkg::OFS_RED)) u_red (
    .clk      (clk),
    .ctl      (ctl),
    .hue_wrap (hue_wrap),
    .chroma   (chroma),
    .light    (light),
    .level    (rgb.red)
  );

  hsl2rgb_chan #(.OFFSET(hsl2rgb_pkg::OFS_GREEN)) u_green (
    .clk      (clk),
    .ctl      (ctl),
    .hue_wrap (hue_wrap),
    .chroma   (chroma),
    .light    (light),
    .level    (rgb.green)
  );

  hsl2rgb_chan #(.OFFSET(hsl2rgb_pkg::OFS_BLUE)) u_blue (
    .clk      (clk),
    .ctl      (ctl),
    .hue_wrap (hue_wrap),
    .chroma   (chroma),
    .light    (light),
    .level    (rgb.blue)
  );

endmodule
